@@ hw/rtl/srq_pkg.sv @@
// srq_pkg: types and constants shared by the sensor reading qualifier
// holds the request and result structs, the register struct and register indexes
// no dependencies
`default_nettype none

package srq_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPIKE_TEMP  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPIKE_HUMID = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FAIL_LIMIT  = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEALTH_TMO  = 2'd3;

  // register reset values
  localparam logic [10:0] SPIKE_TEMP_RESET  = 11'd50;
  localparam logic [10:0] SPIKE_HUMID_RESET = 11'd100;
  localparam logic [7:0]  FAIL_LIMIT_RESET  = 8'd10;
  localparam logic [31:0] HEALTH_TMO_RESET  = 32'd30000;

  // valid window, tenths of a degree and tenths of a percent
  localparam logic signed [11:0] TEMP_MIN  = -12'sd400;
  localparam logic signed [11:0] TEMP_MAX  = 12'sd800;
  localparam logic signed [11:0] HUMID_MIN = 12'sd0;
  localparam logic signed [11:0] HUMID_MAX = 12'sd1000;

  typedef struct packed {
    logic signed [11:0] temp_tenths;
    logic signed [11:0] humid_tenths;
    logic               sample_missing;
    logic [15:0]        read_ms;
    logic [31:0]        now_ms;
  } srq_in_t;

  typedef struct packed {
    logic [31:0] sample_number;
    logic        accepted;
    logic        spike;
    logic        online;
    logic        healthy;
    logic [15:0] avg_read;
    logic [31:0] fail_total;
  } srq_out_t;

  typedef struct packed {
    logic [10:0] spike_temp_limit;
    logic [10:0] spike_humid_limit;
    logic [7:0]  fail_limit;
    logic [31:0] health_timeout;
  } srq_cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/srq_cfg.sv @@
// srq_cfg: configuration register set of the sensor reading qualifier
// write-only registers, masked to their widths; depends on srq_pkg
`default_nettype none

module srq_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [srq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [srq_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output srq_pkg::srq_cfg_t                        cfg
);
  import srq_pkg::*;

  srq_cfg_t regs;

  // register writes by index
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.spike_temp_limit  <= SPIKE_TEMP_RESET;
      regs.spike_humid_limit <= SPIKE_HUMID_RESET;
      regs.fail_limit        <= FAIL_LIMIT_RESET;
      regs.health_timeout    <= HEALTH_TMO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPIKE_TEMP:  regs.spike_temp_limit  <= cfg_data[10:0];
        CFG_SPIKE_HUMID: regs.spike_humid_limit <= cfg_data[10:0];
        CFG_FAIL_LIMIT:  regs.fail_limit        <= cfg_data[7:0];
        CFG_HEALTH_TMO:  regs.health_timeout    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

`default_nettype wire

@@ hw/rtl/srq_core.sv @@
// srq_core: qualification logic, health bookkeeping and the result register
// one request is evaluated per fire strobe; depends on srq_pkg
`default_nettype none

module srq_core #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire srq_pkg::srq_in_t  item,
  input  wire srq_pkg::srq_cfg_t cfg,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output srq_pkg::srq_out_t      out_data
);
  import srq_pkg::*;

  // bookkeeping state
  logic [31:0]            next_number;
  logic signed [11:0]     prev_temp;
  logic signed [11:0]     prev_humid;
  logic                   prev_present;
  logic [COUNT_BITS-1:0]  sample_total;
  logic [COUNT_BITS-1:0]  fail_count;
  logic [31:0]            last_good_time;
  logic [15:0]            read_average;
  logic                   online_flag;

  logic [COUNT_BITS-1:0]  sample_total_next;
  logic [COUNT_BITS-1:0]  fail_count_next;
  logic [31:0]            last_good_time_next;
  logic [15:0]            read_average_next;
  logic                   online_flag_next;

  logic                   ok;
  logic                   spike;
  logic                   healthy;
  logic signed [12:0]     temp_diff;
  logic signed [12:0]     humid_diff;
  logic [12:0]            temp_abs;
  logic [12:0]            humid_abs;
  logic [16:0]            avg_sum;
  logic [31:0]            since_good;
  srq_out_t               result;

  // range check
  always_comb begin
    ok = !item.sample_missing
         && ($signed(item.temp_tenths) >= TEMP_MIN)
         && ($signed(item.temp_tenths) <= TEMP_MAX)
         && ($signed(item.humid_tenths) >= HUMID_MIN)
         && ($signed(item.humid_tenths) <= HUMID_MAX);
  end

  // spike check against the last accepted sample
  always_comb begin
    temp_diff  = 13'($signed(item.temp_tenths)) - 13'(prev_temp);
    humid_diff = 13'($signed(item.humid_tenths)) - 13'(prev_humid);
    temp_abs   = temp_diff[12] ? 13'(-temp_diff) : 13'(temp_diff);
    humid_abs  = humid_diff[12] ? 13'(-humid_diff) : 13'(humid_diff);
    spike = ok && prev_present
            && ((temp_abs > {2'b00, cfg.spike_temp_limit})
                || (humid_abs > {2'b00, cfg.spike_humid_limit}));
  end

  // counters, average and online flag after this sample
  always_comb begin
    sample_total_next = (&sample_total) ? sample_total : sample_total + 1'b1;
    fail_count_next   = fail_count;
    last_good_time_next = last_good_time;
    read_average_next = read_average;
    online_flag_next  = online_flag;
    avg_sum = {1'b0, read_average} + {1'b0, item.read_ms};
    if (ok) begin
      last_good_time_next = item.now_ms;
      read_average_next   = avg_sum[16:1];
      online_flag_next    = 1'b1;
    end else begin
      fail_count_next = (&fail_count) ? fail_count : fail_count + 1'b1;
      if (fail_count_next > COUNT_BITS'(cfg.fail_limit)) begin
        online_flag_next = 1'b0;
      end
    end
  end

  // health verdict
  always_comb begin
    since_good = item.now_ms - last_good_time_next;
    healthy = online_flag_next
              && (since_good < cfg.health_timeout)
              && ({fail_count_next, 1'b0} < {1'b0, sample_total_next});
  end

  // result assembly
  always_comb begin
    result.sample_number = next_number;
    result.accepted      = ok;
    result.spike         = spike;
    result.online        = online_flag_next;
    result.healthy       = healthy;
    result.avg_read      = read_average_next;
    result.fail_total    = 32'(fail_count_next);
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      next_number    <= 32'd1;
      prev_temp      <= '0;
      prev_humid     <= '0;
      prev_present   <= 1'b0;
      sample_total   <= '0;
      fail_count     <= '0;
      last_good_time <= '0;
      read_average   <= '0;
      online_flag    <= 1'b0;
    end else if (fire) begin
      next_number    <= next_number + 32'd1;
      sample_total   <= sample_total_next;
      fail_count     <= fail_count_next;
      last_good_time <= last_good_time_next;
      read_average   <= read_average_next;
      online_flag    <= online_flag_next;
      if (ok) begin
        prev_temp    <= item.temp_tenths;
        prev_humid   <= item.humid_tenths;
        prev_present <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sensor_reading_qualifier.sv @@
// sensor_reading_qualifier: top level with the input register and request handshake
// instantiates srq_cfg and srq_core; depends on srq_pkg
`default_nettype none

// Qualifies one temperature/humidity sample per request: numbers it, checks it
// against -40..80 C and 0..100 %, flags spikes against the last good sample and
// keeps failure counts, a halving read-time average, the online flag and a health
// verdict. One sample is taken every clock cycle unless the result register is
// stalled. A request is caught by the input register and its result is loaded
// into the result register when that register can load, with the single
// evaluation stage in between. Samples are strictly serialised through the
// bookkeeping state, which is updated as each sample leaves the input register.
// Configuration is to be written through cfg_we/cfg_index/cfg_data only while no
// sample is in flight; the block itself does not enforce this.
module sensor_reading_qualifier #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire srq_pkg::srq_in_t                    in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output srq_pkg::srq_out_t                        out_data,
  input  wire logic                                cfg_we,
  input  wire logic [srq_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [srq_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import srq_pkg::*;

  srq_cfg_t cfg;
  srq_in_t  in_reg;
  logic     in_reg_valid;
  logic     advance;
  logic     fire;
  logic     take;

  // handshake: the input register drains whenever the result register can load
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;
  assign take     = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (take) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_reg <= in_data;
    end
  end

  srq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srq_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (in_reg),
    .cfg       (cfg),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
